@@ rtl/lpc_residual_restore_core_macros.svh @@
// ---------------------------------------------------------------------------
// lpc residual restore assertion macros
// clocked property checks with asynchronous active-low reset disable
// ---------------------------------------------------------------------------
`ifndef LPC_RESIDUAL_RESTORE_CORE_MACROS_SVH
`define LPC_RESIDUAL_RESTORE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every rising edge outside reset
`define LRR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent overlapped with consequent
`define LRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/lrr_pkg.sv @@
// ---------------------------------------------------------------------------
// lrr_pkg
// shared constants, codes and types of the lpc residual restore core
// ---------------------------------------------------------------------------
package lrr_pkg;

	localparam int MAX_ORDER = 32;
	localparam int COEF_BITS = 15;
	localparam int TAP_BITS  = $clog2(MAX_ORDER);

	localparam int ORDER_W   = 6;
	localparam int SHIFT_W   = 4;
	localparam int DEPTH_W   = 6;
	localparam int CIDX_W    = 5;
	localparam int CVAL_W    = 15;
	localparam int SAMPLE_W  = 36;
	localparam int HIST_W    = 33;
	localparam int PROD_W    = HIST_W + COEF_BITS;
	localparam int ACC_W     = PROD_W + TAP_BITS;
	localparam int VAL_W     = ((ACC_W > SAMPLE_W) ? ACC_W : SAMPLE_W) + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_LPC_ORDER    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SHIFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DEPTH = 2'd2;

	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic acc_clear;
		logic shift_en;
		logic fire;
	} mac_ctl_t;

endpackage

@@ rtl/lrr_mac.sv @@
// ---------------------------------------------------------------------------
// lrr_mac
// shared multiply-accumulate, prediction shift with residual add, clamp
// ---------------------------------------------------------------------------
module lrr_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lrr_pkg::mac_ctl_t                     ctl,
	input  logic signed [lrr_pkg::HIST_W-1:0]     hist_tap,
	input  logic signed [lrr_pkg::COEF_BITS-1:0]  coef_tap,
	input  logic signed [lrr_pkg::SAMPLE_W-1:0]   residual,
	input  logic        [lrr_pkg::SHIFT_W-1:0]    quant_shift,
	input  logic        [lrr_pkg::DEPTH_W-1:0]    depth,
	output logic signed [lrr_pkg::HIST_W-1:0]     value,
	output logic                                  clamped
);

	logic signed [lrr_pkg::PROD_W-1:0] product_s1;
	logic                              prod_valid_s1;
	logic signed [lrr_pkg::ACC_W-1:0]  acc_q;
	logic signed [lrr_pkg::VAL_W-1:0]  val_q;
	logic signed [lrr_pkg::ACC_W-1:0]  acc_shifted;
	logic signed [lrr_pkg::VAL_W-1:0]  hi_lim;
	logic signed [lrr_pkg::VAL_W-1:0]  lo_lim;
	logic        [lrr_pkg::DEPTH_W-1:0] dep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
		end else begin
			prod_valid_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			product_s1 <= hist_tap * coef_tap;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_clear) begin
			acc_q <= '0;
		end else if (prod_valid_s1) begin
			acc_q <= acc_q + lrr_pkg::ACC_W'(product_s1);
		end
	end

	assign acc_shifted = acc_q >>> quant_shift;

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			val_q <= lrr_pkg::VAL_W'(residual) + lrr_pkg::VAL_W'(acc_shifted);
		end
	end

	// depth limited to 1..33
	always_comb begin
		if (depth == '0) begin
			dep = lrr_pkg::DEPTH_W'(1);
		end else if (depth > lrr_pkg::DEPTH_W'(lrr_pkg::HIST_W)) begin
			dep = lrr_pkg::DEPTH_W'(lrr_pkg::HIST_W);
		end else begin
			dep = depth;
		end
	end

	assign hi_lim = $signed((lrr_pkg::VAL_W'(1) << (dep - lrr_pkg::DEPTH_W'(1)))
		- lrr_pkg::VAL_W'(1));
	assign lo_lim = ~hi_lim;

	always_comb begin
		priority if (val_q < lo_lim) begin
			value   = lo_lim[lrr_pkg::HIST_W-1:0];
			clamped = 1'b1;
		end else if (val_q > hi_lim) begin
			value   = hi_lim[lrr_pkg::HIST_W-1:0];
			clamped = 1'b1;
		end else begin
			value   = val_q[lrr_pkg::HIST_W-1:0];
			clamped = 1'b0;
		end
	end

endmodule

@@ rtl/lrr_ctrl.sv @@
// ---------------------------------------------------------------------------
// lrr_ctrl
// sequencer stepping the shared multiply-accumulate over the taps
// ---------------------------------------------------------------------------
`include "lpc_residual_restore_core_macros.svh"

module lrr_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               predict,
	input  logic [lrr_pkg::ORDER_W-1:0]        ord,
	input  logic                               out_free,
	output logic                               busy,
	output logic [lrr_pkg::TAP_BITS-1:0]       tap,
	output lrr_pkg::mac_ctl_t                  ctl
);

	lrr_pkg::state_t state_q;
	lrr_pkg::state_t state_d;
	logic [lrr_pkg::TAP_BITS-1:0] tap_q;
	logic last_tap;

	assign last_tap = ({1'b0, tap_q} == (ord - lrr_pkg::ORDER_W'(1)));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrr_pkg::S_IDLE: begin
				if (start) begin
					state_d = predict ? lrr_pkg::S_MAC : lrr_pkg::S_SHIFT;
				end
			end
			lrr_pkg::S_MAC: begin
				if (last_tap) begin
					state_d = lrr_pkg::S_DRAIN;
				end
			end
			lrr_pkg::S_DRAIN: begin
				state_d = lrr_pkg::S_SHIFT;
			end
			lrr_pkg::S_SHIFT: begin
				state_d = lrr_pkg::S_DONE;
			end
			lrr_pkg::S_DONE: begin
				if (out_free) begin
					state_d = lrr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lrr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.mul_en    = (state_q == lrr_pkg::S_MAC);
		ctl.acc_clear = (state_q == lrr_pkg::S_IDLE) && start;
		ctl.shift_en  = (state_q == lrr_pkg::S_SHIFT);
		ctl.fire      = (state_q == lrr_pkg::S_DONE) && out_free;
		busy          = (state_q != lrr_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.acc_clear) begin
			tap_q <= '0;
		end else if (ctl.mul_en) begin
			tap_q <= tap_q + lrr_pkg::TAP_BITS'(1);
		end
	end

	assign tap = tap_q;

	`LRR_ASSERT_IMP(a_tap_in_order, clk, arst_n, state_q == lrr_pkg::S_MAC, lrr_pkg::ORDER_W'(tap_q) < ord, "tap beyond order")
	`LRR_ASSERT_NXT(a_start_mac, clk, arst_n, (state_q == lrr_pkg::S_IDLE) && start && predict, state_q == lrr_pkg::S_MAC && tap_q == '0, "predicted sample did not enter mac")
	`LRR_ASSERT_NXT(a_start_warm, clk, arst_n, (state_q == lrr_pkg::S_IDLE) && start && !predict, state_q == lrr_pkg::S_SHIFT, "warm-up sample did not skip mac")
	`LRR_ASSERT_NXT(a_fire_idle, clk, arst_n, ctl.fire, state_q == lrr_pkg::S_IDLE && !busy, "sequencer not idle after result")

endmodule

@@ rtl/lpc_residual_restore_core.sv @@
// ---------------------------------------------------------------------------
// lpc_residual_restore_core
// lpc synthesis filter: rebuilds samples from residuals with a
// coefficient store, a sample history and one shared multiply-accumulate
//
//  channel  handshake                  word
//  item     item_valid / item_stall    opcode, coef_index, coef_value,
//                                      sample_value, block_start
//  result   result_valid / result_stall sample_out, out_of_range, is_warmup
//  cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  predicted sample, order n: mac over n taps, drain, shift, done, one tap
//  per cycle through the single multiplier and accumulator
//  warm-up sample or order zero: shift, done; coefficient: stored on accept
//  next word taken in the cycle after the result register loads
//  a stalled result holds the sequencer in its last step, item_stall high
// ---------------------------------------------------------------------------
module lpc_residual_restore_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  opcode,
	input  logic        [lrr_pkg::CIDX_W-1:0]     coef_index,
	input  logic signed [lrr_pkg::CVAL_W-1:0]     coef_value,
	input  logic signed [lrr_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic                                  block_start,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [lrr_pkg::HIST_W-1:0]     sample_out,
	output logic                                  out_of_range,
	output logic                                  is_warmup,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [lrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [lrr_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [lrr_pkg::ORDER_W-1:0] lpc_order_q;
	logic [lrr_pkg::SHIFT_W-1:0] quant_shift_q;
	logic [lrr_pkg::DEPTH_W-1:0] sample_depth_q;

	logic signed [lrr_pkg::HIST_W-1:0]    hist_q [lrr_pkg::MAX_ORDER];
	logic signed [lrr_pkg::COEF_BITS-1:0] coef_q [lrr_pkg::MAX_ORDER];
	logic [lrr_pkg::ORDER_W-1:0] pos_q;
	logic signed [lrr_pkg::SAMPLE_W-1:0] residual_q;
	logic warm_q;

	logic result_valid_q;
	logic signed [lrr_pkg::HIST_W-1:0] sample_out_q;
	logic out_of_range_q;
	logic is_warmup_q;

	logic item_acc;
	logic start;
	logic coef_wr;
	logic [lrr_pkg::ORDER_W-1:0] ord;
	logic [lrr_pkg::ORDER_W-1:0] pos_now;
	logic warm;
	logic predict;
	logic out_free;
	logic busy;
	logic [lrr_pkg::TAP_BITS-1:0] tap;
	lrr_pkg::mac_ctl_t ctl;
	logic signed [lrr_pkg::HIST_W-1:0] mac_value;
	logic mac_clamped;

	assign item_acc   = item_valid && !item_stall;
	assign start      = item_acc && (opcode == lrr_pkg::OP_SAMPLE);
	assign coef_wr    = item_acc && (opcode == lrr_pkg::OP_COEF)
		&& (32'(coef_index) < lrr_pkg::MAX_ORDER);
	assign item_stall = busy;
	assign cfg_ready  = 1'b1;

	assign ord = (lpc_order_q > lrr_pkg::ORDER_W'(lrr_pkg::MAX_ORDER))
		? lrr_pkg::ORDER_W'(lrr_pkg::MAX_ORDER) : lpc_order_q;
	assign pos_now  = block_start ? '0 : pos_q;
	assign warm     = (pos_now < ord);
	assign predict  = !warm && (ord != '0);
	assign out_free = !result_valid_q || !result_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpc_order_q    <= '0;
			quant_shift_q  <= '0;
			sample_depth_q <= lrr_pkg::DEPTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lrr_pkg::CFG_LPC_ORDER: begin
					lpc_order_q <= cfg_data[lrr_pkg::ORDER_W-1:0];
				end
				lrr_pkg::CFG_QUANT_SHIFT: begin
					quant_shift_q <= cfg_data[lrr_pkg::SHIFT_W-1:0];
				end
				lrr_pkg::CFG_SAMPLE_DEPTH: begin
					sample_depth_q <= cfg_data[lrr_pkg::DEPTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// coefficient store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lrr_pkg::MAX_ORDER; i++) begin
				coef_q[i] <= '0;
			end
		end else if (coef_wr) begin
			coef_q[coef_index[lrr_pkg::TAP_BITS-1:0]] <= coef_value[lrr_pkg::COEF_BITS-1:0];
		end
	end

	// sample history, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lrr_pkg::MAX_ORDER; i++) begin
				hist_q[i] <= '0;
			end
		end else if (ctl.fire) begin
			for (int i = lrr_pkg::MAX_ORDER - 1; i > 0; i--) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= mac_value;
		end
	end

	// block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (start) begin
			pos_q <= warm ? (pos_now + lrr_pkg::ORDER_W'(1)) : pos_now;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			residual_q <= sample_value;
			warm_q     <= warm;
		end
	end

	lrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.predict  (predict),
		.ord      (ord),
		.out_free (out_free),
		.busy     (busy),
		.tap      (tap),
		.ctl      (ctl)
	);

	lrr_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.hist_tap    (hist_q[tap]),
		.coef_tap    (coef_q[tap]),
		.residual    (residual_q),
		.quant_shift (quant_shift_q),
		.depth       (sample_depth_q),
		.value       (mac_value),
		.clamped     (mac_clamped)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			sample_out_q   <= mac_value;
			out_of_range_q <= mac_clamped;
			is_warmup_q    <= warm_q;
		end
	end

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;
	assign out_of_range = out_of_range_q;
	assign is_warmup    = is_warmup_q;

endmodule

@@ verif/lpc_residual_restore_core_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lpc_residual_restore_core_test
// drives coefficient and sample words into the lpc synthesis filter under
// random idling and stalls on both sides, predicts every restored sample,
// warm-up flag and range flag, and compares them in order at the result port
// ---------------------------------------------------------------------------
module lpc_residual_restore_core_test;

	import lrr_pkg::*;

	localparam int ITEM_TARGET   = 1600;
	localparam int DRAIN_CYCLES  = MAX_ORDER + 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_REPORTS   = 10;
	localparam longint LIMIT_NS  = 64'd10_000_000;

	typedef struct packed {
		logic [HIST_W-1:0] sample;
		logic              oor;
		logic              warm;
	} restored_t;

	class restore_scoreboard;
		logic signed [HIST_W-1:0]    history [MAX_ORDER];
		logic signed [COEF_BITS-1:0] taps [MAX_ORDER];
		int unsigned                 position;
		logic [ORDER_W-1:0]          order;
		logic [SHIFT_W-1:0]          shift;
		logic [DEPTH_W-1:0]          depth;
		restored_t                   expected_samples [$];
		int                          errors;

		function new();
			foreach (history[i]) history[i] = '0;
			foreach (taps[i]) taps[i] = '0;
			position = 0;
			order    = '0;
			shift    = '0;
			depth    = DEPTH_RESET;
			errors   = 0;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LPC_ORDER:    order = data[ORDER_W-1:0];
				CFG_QUANT_SHIFT:  shift = data[SHIFT_W-1:0];
				CFG_SAMPLE_DEPTH: depth = data[DEPTH_W-1:0];
				default: ;
			endcase
		endfunction

		function restored_t restore_sample(logic signed [SAMPLE_W-1:0] sval, logic bstart);
			int unsigned ord;
			int unsigned d;
			longint      value;
			longint      sum;
			longint      hi;
			longint      lo;
			restored_t   w;
			if (bstart)
				position = 0;
			ord = (order > MAX_ORDER) ? MAX_ORDER : order;
			d = (depth < 1) ? 1 : ((depth > 33) ? 33 : depth);
			hi = (longint'(1) <<< (d - 1)) - 1;
			lo = -hi - 1;
			value = sval;
			w.warm = (position < ord);
			w.oor = 1'b0;
			if (w.warm) begin
				position++;
			end else begin
				sum = 0;
				for (int j = 0; j < ord; j++)
					sum += longint'(history[j]) * longint'(taps[j]);
				value += sum >>> shift;
			end
			if (value < lo) begin
				value = lo;
				w.oor = 1'b1;
			end
			if (value > hi) begin
				value = hi;
				w.oor = 1'b1;
			end
			for (int j = MAX_ORDER - 1; j > 0; j--)
				history[j] = history[j-1];
			history[0] = value[HIST_W-1:0];
			w.sample = value[HIST_W-1:0];
			return w;
		endfunction

		function void note_item(logic op, logic [CIDX_W-1:0] idx,
				logic signed [CVAL_W-1:0] cval, logic signed [SAMPLE_W-1:0] sval,
				logic bstart);
			if (op == OP_COEF)
				taps[idx] = cval;
			else
				expected_samples.push_back(restore_sample(sval, bstart));
		endfunction

		function void check_result(logic [HIST_W-1:0] s, logic oor, logic warm);
			restored_t w;
			if (expected_samples.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected word: sample_out %0d out_of_range %0b is_warmup %0b",
						$signed(s), oor, warm);
			end else begin
				w = expected_samples.pop_front();
				if (w.sample !== s || w.oor !== oor || w.warm !== warm) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
							$signed(w.sample), w.oor, w.warm, $signed(s), oor, warm);
				end
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	logic                          opcode       = OP_SAMPLE;
	logic        [CIDX_W-1:0]      coef_index   = '0;
	logic signed [CVAL_W-1:0]      coef_value   = '0;
	logic signed [SAMPLE_W-1:0]    sample_value = '0;
	logic                          block_start  = 1'b0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic signed [HIST_W-1:0]      sample_out;
	logic                          out_of_range;
	logic                          is_warmup;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic        [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic        [CFG_DATA_W-1:0]  cfg_data     = '0;

	restore_scoreboard sb;
	bit tx_fast  = 1'b0;
	bit rx_fast  = 1'b0;
	bit hold_req = 1'b0;
	int n_sent   = 0;

	int fixed_taps [5][4] = '{'{0, 0, 0, 0}, '{1, 0, 0, 0}, '{2, -1, 0, 0},
		'{3, -3, 1, 0}, '{4, -6, 4, -1}};

	lpc_residual_restore_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.sample_value (sample_value),
		.block_start  (block_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_out   (sample_out),
		.out_of_range (out_of_range),
		.is_warmup    (is_warmup),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_word(input logic op, input logic [CIDX_W-1:0] idx,
			input logic signed [CVAL_W-1:0] cval, input logic signed [SAMPLE_W-1:0] sval,
			input logic bstart);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		opcode       <= op;
		coef_index   <= idx;
		coef_value   <= cval;
		sample_value <= sval;
		block_start  <= bstart;
		do @(posedge clk); while (item_stall);
		sb.note_item(op, idx, cval, sval, bstart);
		n_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] order,
			input logic [CFG_DATA_W-1:0] shift, input logic [CFG_DATA_W-1:0] depth);
		logic [CFG_IDX_W-1:0]  regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs = '{CFG_LPC_ORDER, CFG_QUANT_SHIFT, CFG_SAMPLE_DEPTH};
		vals = '{order, shift, depth};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.note_config(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(int d, bit residual);
		longint r;
		int     sh;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: sh = 0;
			1: begin
				r = 64'sh7_FFFF_FFFF;
				sh = 0;
			end
			2: begin
				r = -64'sh8_0000_0000;
				sh = 0;
			end
			default: sh = 64 - d + (residual ? $urandom_range(1, d / 2 + 2) : $urandom_range(0, 1));
		endcase
		r = r >>> sh;
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [CVAL_W-1:0] pick_coef(int style, int ord, int tap);
		logic signed [CVAL_W-1:0] c;
		c = $signed(CVAL_W'($urandom));
		case (style)
			0: return CVAL_W'(fixed_taps[ord][tap]);
			1: return c >>> $urandom_range(0, 3);
			2: return c;
			default: return c >>> $urandom_range(4, 8);
		endcase
	endfunction

	task automatic run_random_phase(input bit with_hold);
		int style;
		int ord;
		int d;
		int len;
		int n;
		int target;
		logic [CFG_DATA_W-1:0] order_r;
		logic [CFG_DATA_W-1:0] shift_r;
		logic [CFG_DATA_W-1:0] depth_r;
		style = $urandom_range(0, 3);
		case (style)
			0: begin
				order_r = CFG_DATA_W'($urandom_range(0, 4));
				shift_r = '0;
				depth_r = CFG_DATA_W'($urandom_range(8, 33));
			end
			1: begin
				order_r = CFG_DATA_W'($urandom_range(1, 12));
				shift_r = CFG_DATA_W'($urandom_range(8, 15));
				depth_r = CFG_DATA_W'($urandom_range(12, 33));
			end
			2: begin
				order_r = CFG_DATA_W'($urandom);
				shift_r = CFG_DATA_W'($urandom);
				depth_r = CFG_DATA_W'($urandom);
			end
			default: begin
				order_r = CFG_DATA_W'($urandom_range(24, 32));
				shift_r = CFG_DATA_W'($urandom_range(10, 15));
				depth_r = CFG_DATA_W'($urandom_range(16, 24));
			end
		endcase
		wait_drained();
		set_config(order_r, shift_r, depth_r);
		ord = (order_r > MAX_ORDER) ? MAX_ORDER : order_r;
		d = (depth_r < 1) ? 1 : ((depth_r > 33) ? 33 : depth_r);
		tx_fast = with_hold || ($urandom_range(0, 3) == 0);
		if (with_hold)
			hold_req = 1'b1;
		for (int j = 0; j < ord; j++)
			send_word(OP_COEF, CIDX_W'(j), pick_coef(style, ord, j), pick_sample(36, 0),
				1'($urandom));
		n = 0;
		target = $urandom_range(30, 90);
		while (n < target) begin
			len = $urandom_range(1, 3 * ord + 8);
			for (int k = 0; k < len && n < target; k++) begin
				case ($urandom_range(0, 29))
					0: send_word(OP_COEF, CIDX_W'($urandom), pick_coef(2, ord, 0),
						pick_sample(36, 0), 1'($urandom));
					1: wait_drained();
					default: ;
				endcase
				send_word(OP_SAMPLE, CIDX_W'($urandom), $signed(CVAL_W'($urandom)),
					pick_sample(d, k >= ord), (k == 0) || ($urandom_range(0, 40) == 0));
				n++;
			end
		end
	endtask

	// result side: random stalls, one long hold on request
	initial begin
		int stall_n;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0)
				rx_fast = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				stall_n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall_n = rx_fast ? 0 : $urandom_range(0, 16);
			end
			if (stall_n > 0) begin
				result_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_result(sample_out, out_of_range, is_warmup);
			taken++;
		end
	end

	initial begin
		int phase_no;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, no block start yet
		send_word(OP_SAMPLE, 5'd31, 15'sh3FFF, 36'sh7_FFFF_FFFF, 1'b0);
		send_word(OP_SAMPLE, 5'd0, -15'sh4000, 36'sh8_0000_0000, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd0, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd32767, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, -36'sd32768, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd32768, 1'b0);

		// second order fixed predictor, widest depth
		wait_drained();
		set_config(6'd2, 6'd0, 6'd33);
		send_word(OP_COEF, 5'd0, 15'sd2, 36'sd0, 1'b0);
		send_word(OP_COEF, 5'd1, -15'sd1, 36'sd0, 1'b1);
		send_word(OP_COEF, 5'd31, -15'sd16384, 36'sh8_0000_0000, 1'b1);
		send_word(OP_COEF, 5'd30, 15'sd16383, 36'sh7_FFFF_FFFF, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd1000, 1'b1);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd1010, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd3, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, -36'sd7, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sh7_FFFF_FFFF, 1'b0);

		// order above max, largest shift, zero depth
		wait_drained();
		set_config(6'd63, 6'd47, 6'd0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sd1, 1'b1);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, -36'sd5, 1'b0);

		// order dropped mid-block, depth above 33
		wait_drained();
		set_config(6'd1, 6'd0, 6'd63);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sh7_FFFF_FFFF, 1'b0);
		send_word(OP_SAMPLE, 5'd0, 15'sd0, 36'sh8_0000_0000, 1'b0);

		phase_no = 0;
		while (n_sent < ITEM_TARGET + 19) begin
			run_random_phase(phase_no == 2);
			phase_no++;
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
